### hw/rtl/tcmq_pkg.sv
// ----------------------------------------------------------------------------
// tcmq_pkg
// Types, constants and helpers shared by the two-class message queue.
// ----------------------------------------------------------------------------
package tcmq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int HANDLE_W    = 16;
    localparam int TAG_W       = 16;
    localparam int CNT_W       = 6;
    localparam int DATA_W      = HANDLE_W + TAG_W;

    typedef enum logic [1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_REVOKE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_DEQ     = 2'd1,
        KIND_REVOKED = 2'd2,
        KIND_DONE    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_ENQ_LINK,
        S_ENQ_FIX,
        S_DEQ,
        S_REV_RD,
        S_REV_CHK,
        S_REV_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]          kind;
        logic [1:0]          status;
        logic [HANDLE_W-1:0] out_handle;
        logic [TAG_W-1:0]    out_tag;
        logic [CNT_W-1:0]    revoked_count;
        logic                signal;
        logic                last;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } t_mem_ctl;

    function automatic logic [SLOT_W-1:0] first_free(input logic [QUEUE_DEPTH-1:0] f);
        logic [SLOT_W-1:0] s;
        s = '0;
        for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
            if (f[k]) begin
                s = SLOT_W'(k);
            end
        end
        return s;
    endfunction

endpackage

### hw/rtl/tcmq_in_if.sv
// ----------------------------------------------------------------------------
// tcmq_in_if
// Command channel of the message queue.
// ----------------------------------------------------------------------------
interface tcmq_in_if import tcmq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    logic                high_priority;
    logic [HANDLE_W-1:0] payload_handle;
    logic [TAG_W-1:0]    context_tag;
    logic                revoke_all;
    logic [CNT_W-1:0]    revoke_limit;

    modport source (output valid, cmd, high_priority, payload_handle, context_tag,
                    revoke_all, revoke_limit, input ready);
    modport sink (input valid, cmd, high_priority, payload_handle, context_tag,
                  revoke_all, revoke_limit, output ready);
endinterface

### hw/rtl/tcmq_out_if.sv
// ----------------------------------------------------------------------------
// tcmq_out_if
// Result channel of the message queue.
// ----------------------------------------------------------------------------
interface tcmq_out_if import tcmq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [1:0]          status;
    logic [HANDLE_W-1:0] out_handle;
    logic [TAG_W-1:0]    out_tag;
    logic [CNT_W-1:0]    revoked_count;
    logic                signal;
    logic                last;

    modport source (output valid, kind, status, out_handle, out_tag, revoked_count,
                    signal, last, input ready);
    modport sink (input valid, kind, status, out_handle, out_tag, revoked_count,
                  signal, last, output ready);
endinterface

### hw/rtl/tcmq_cfg_if.sv
// ----------------------------------------------------------------------------
// tcmq_cfg_if
// Configuration write channel carrying the signal enable bit.
// ----------------------------------------------------------------------------
interface tcmq_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### hw/rtl/tcmq_ram.sv
// ----------------------------------------------------------------------------
// tcmq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/tcmq_seq.sv
// ----------------------------------------------------------------------------
// tcmq_seq
// Queue sequencer: pointer state, slot allocation, list walk and result register.
// ----------------------------------------------------------------------------
module tcmq_seq import tcmq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_signal_enable,
    tcmq_in_if.sink             i_cmd_ch,
    tcmq_out_if.source          o_res_ch,
    output t_mem_ctl            o_data_ctl,
    output logic [DATA_W-1:0]   o_data_wdata,
    input  logic [DATA_W-1:0]   i_data_rdata,
    output t_mem_ctl            o_link_ctl,
    output logic [SLOT_W-1:0]   o_link_wdata,
    input  logic [SLOT_W-1:0]   i_link_rdata
);
    t_state                r_state, n_state;
    logic [QUEUE_DEPTH-1:0] r_free, n_free;
    logic [SLOT_W-1:0]     r_head, n_head, r_tail, n_tail, r_ptail, n_ptail;
    logic                  r_pv, n_pv;
    logic [OCC_W-1:0]      r_occ, n_occ, r_i, n_i, r_n, n_n;
    logic [SLOT_W-1:0]     r_cur, n_cur, r_prev, n_prev, r_slot, n_slot;
    logic                  r_hprev, n_hprev;
    logic [CNT_W-1:0]      r_did, n_did, w_did1;
    logic                  r_prio, n_prio, r_all, n_all;
    logic [HANDLE_W-1:0]   r_handle, n_handle;
    logic [TAG_W-1:0]      r_tag, n_tag;
    logic [CNT_W-1:0]      r_limit, n_limit;
    logic                  r_ovalid, n_ovalid;
    t_result               r_out, n_out;
    logic                  w_can_emit, w_match;

    assign w_can_emit = !r_ovalid || o_res_ch.ready;
    assign w_did1     = r_did + CNT_W'(1);
    assign w_match    = r_all || (i_data_rdata[TAG_W-1:0] == r_tag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_free   <= '1;
            r_head   <= '0;
            r_tail   <= '0;
            r_ptail  <= '0;
            r_pv     <= 1'b0;
            r_occ    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_free   <= n_free;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_ptail  <= n_ptail;
            r_pv     <= n_pv;
            r_occ    <= n_occ;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_n      <= n_n;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_slot   <= n_slot;
        r_hprev  <= n_hprev;
        r_did    <= n_did;
        r_prio   <= n_prio;
        r_all    <= n_all;
        r_handle <= n_handle;
        r_tag    <= n_tag;
        r_limit  <= n_limit;
        r_out    <= n_out;
    end

    always_comb begin
        n_state  = r_state;
        n_free   = r_free;
        n_head   = r_head;
        n_tail   = r_tail;
        n_ptail  = r_ptail;
        n_pv     = r_pv;
        n_occ    = r_occ;
        n_i      = r_i;
        n_n      = r_n;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_slot   = r_slot;
        n_hprev  = r_hprev;
        n_did    = r_did;
        n_prio   = r_prio;
        n_all    = r_all;
        n_handle = r_handle;
        n_tag    = r_tag;
        n_limit  = r_limit;
        n_out    = r_out;
        n_ovalid = r_ovalid && !o_res_ch.ready;
        i_cmd_ch.ready = 1'b0;
        o_data_ctl   = '{we: 1'b0, waddr: r_slot, re: 1'b0, raddr: r_cur};
        o_data_wdata = {r_handle, r_tag};
        o_link_ctl   = '{we: 1'b0, waddr: r_slot, re: 1'b0, raddr: r_cur};
        o_link_wdata = r_head;

        case (r_state)
            S_IDLE: begin
                i_cmd_ch.ready = 1'b1;
                o_data_ctl.raddr = r_head;
                o_link_ctl.raddr = r_head;
                if (i_cmd_ch.valid) begin
                    n_prio   = i_cmd_ch.high_priority;
                    n_handle = i_cmd_ch.payload_handle;
                    n_tag    = i_cmd_ch.context_tag;
                    n_all    = i_cmd_ch.revoke_all;
                    n_limit  = i_cmd_ch.revoke_limit;
                    n_slot   = first_free(r_free);
                    n_cur    = r_head;
                    n_i      = '0;
                    n_n      = r_occ;
                    n_did    = '0;
                    n_hprev  = 1'b0;
                    case (t_cmd'(i_cmd_ch.cmd))
                        CMD_ENQ: n_state = S_ENQ;
                        CMD_DEQ: begin
                            o_data_ctl.re = 1'b1;
                            o_link_ctl.re = 1'b1;
                            n_state = S_DEQ;
                        end
                        CMD_REVOKE: n_state = S_REV_RD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ENQ: begin
                if (w_can_emit) begin
                    n_ovalid = 1'b1;
                    n_out = '{kind: KIND_ACK, status: ST_OK, out_handle: '0, out_tag: '0,
                              revoked_count: '0, signal: 1'b0, last: 1'b1};
                    n_state = S_IDLE;
                    if (r_occ == OCC_W'(QUEUE_DEPTH)) begin
                        n_out.status = ST_FULL;
                    end else begin
                        o_data_ctl.we = 1'b1;
                        n_free[r_slot] = 1'b0;
                        n_occ = r_occ + OCC_W'(1);
                        if (r_occ == '0) begin
                            n_head  = r_slot;
                            n_tail  = r_slot;
                            n_ptail = r_slot;
                            n_pv    = r_prio;
                            n_out.signal = i_signal_enable;
                        end else if (r_prio && !r_pv) begin
                            o_link_ctl.we = 1'b1;
                            o_link_wdata  = r_head;
                            n_head  = r_slot;
                            n_ptail = r_slot;
                            n_pv    = 1'b1;
                        end else if (r_prio) begin
                            o_link_ctl.re    = 1'b1;
                            o_link_ctl.raddr = r_ptail;
                            n_state = S_ENQ_LINK;
                        end else begin
                            o_link_ctl.we    = 1'b1;
                            o_link_ctl.waddr = r_tail;
                            o_link_wdata     = r_slot;
                            n_tail = r_slot;
                        end
                    end
                end
            end
            S_ENQ_LINK: begin
                o_link_ctl.we = 1'b1;
                o_link_wdata  = i_link_rdata;
                n_state = S_ENQ_FIX;
            end
            S_ENQ_FIX: begin
                o_link_ctl.we    = 1'b1;
                o_link_ctl.waddr = r_ptail;
                o_link_wdata     = r_slot;
                if (r_tail == r_ptail) begin
                    n_tail = r_slot;
                end
                n_ptail = r_slot;
                n_state = S_IDLE;
            end
            S_DEQ: begin
                if (w_can_emit) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                    n_out = '{kind: KIND_DEQ, status: ST_OK,
                              out_handle: i_data_rdata[DATA_W-1:TAG_W],
                              out_tag: i_data_rdata[TAG_W-1:0],
                              revoked_count: '0, signal: 1'b0, last: 1'b1};
                    if (r_occ == '0) begin
                        n_out.status     = ST_EMPTY;
                        n_out.out_handle = '0;
                        n_out.out_tag    = '0;
                    end else begin
                        if (r_pv && r_ptail == r_head) begin
                            n_pv = 1'b0;
                        end
                        n_head = i_link_rdata;
                        n_free[r_head] = 1'b1;
                        n_occ = r_occ - OCC_W'(1);
                    end
                end
            end
            S_REV_RD: begin
                if (r_i < r_n) begin
                    o_data_ctl.re = 1'b1;
                    o_link_ctl.re = 1'b1;
                    n_state = S_REV_CHK;
                end else begin
                    n_state = S_REV_DONE;
                end
            end
            S_REV_CHK: begin
                if (!w_match) begin
                    n_prev  = r_cur;
                    n_hprev = 1'b1;
                    n_cur   = i_link_rdata;
                    n_i     = r_i + OCC_W'(1);
                    n_state = S_REV_RD;
                end else if (w_can_emit) begin
                    n_ovalid = 1'b1;
                    n_out = '{kind: KIND_REVOKED, status: ST_OK,
                              out_handle: i_data_rdata[DATA_W-1:TAG_W],
                              out_tag: i_data_rdata[TAG_W-1:0],
                              revoked_count: w_did1, signal: 1'b0, last: 1'b0};
                    if (r_hprev) begin
                        o_link_ctl.we    = 1'b1;
                        o_link_ctl.waddr = r_prev;
                        o_link_wdata     = i_link_rdata;
                    end else begin
                        n_head = i_link_rdata;
                    end
                    if (r_tail == r_cur) begin
                        n_tail = r_hprev ? r_prev : '0;
                    end
                    if (r_pv && r_ptail == r_cur) begin
                        if (r_hprev) begin
                            n_ptail = r_prev;
                        end else begin
                            n_pv = 1'b0;
                        end
                    end
                    n_free[r_cur] = 1'b1;
                    n_occ = r_occ - OCC_W'(1);
                    n_did = w_did1;
                    n_cur = i_link_rdata;
                    n_i   = r_i + OCC_W'(1);
                    if (r_limit != '0 && w_did1 >= r_limit) begin
                        n_state = S_REV_DONE;
                    end else begin
                        n_state = S_REV_RD;
                    end
                end
            end
            S_REV_DONE: begin
                if (w_can_emit) begin
                    n_ovalid = 1'b1;
                    n_out = '{kind: KIND_DONE, status: ST_OK, out_handle: '0, out_tag: '0,
                              revoked_count: r_did, signal: 1'b0, last: 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_res_ch.valid         = r_ovalid;
    assign o_res_ch.kind          = r_out.kind;
    assign o_res_ch.status        = r_out.status;
    assign o_res_ch.out_handle    = r_out.out_handle;
    assign o_res_ch.out_tag       = r_out.out_tag;
    assign o_res_ch.revoked_count = r_out.revoked_count;
    assign o_res_ch.signal        = r_out.signal;
    assign o_res_ch.last          = r_out.last;

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_free_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_free) + int'(r_occ) == QUEUE_DEPTH)
        else $error("free map disagrees with occupancy");

    a_cmd_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_ch.valid && i_cmd_ch.ready && i_cmd_ch.cmd != CMD_NONE)
        |=> r_state != S_IDLE)
        else $error("accepted command did not start");
endmodule

### hw/rtl/two_class_message_queue_with_revoke.sv
// ----------------------------------------------------------------------------
// two_class_message_queue_with_revoke
// Bounded two-class message queue with tag revoke, top level.
// ----------------------------------------------------------------------------
// The queue takes one command beat at a time and is not ready again until the
// command is finished. Enqueue passes through S_ENQ, and a priority entry behind
// earlier priority entries also through S_ENQ_LINK and S_ENQ_FIX; dequeue passes
// through S_DEQ; revoke alternates S_REV_RD and S_REV_CHK for each visited entry
// and ends in S_REV_DONE. These steps are set by the single read port and the
// registered read data of the slot and link memories. Result beats are held in
// an output register, so a stalled result delays only the next result.
module two_class_message_queue_with_revoke import tcmq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcmq_in_if.sink     i_cmd_ch,
    tcmq_out_if.source  o_res_ch,
    tcmq_cfg_if.sink    i_cfg_ch
);
    logic              r_signal_enable;
    t_mem_ctl          w_data_ctl, w_link_ctl;
    logic [DATA_W-1:0] w_data_wdata, w_data_rdata;
    logic [SLOT_W-1:0] w_link_wdata, w_link_rdata;

    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signal_enable <= 1'b0;
        end else if (i_cfg_ch.valid) begin
            r_signal_enable <= i_cfg_ch.data;
        end
    end

    tcmq_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_signal_enable (r_signal_enable),
        .i_cmd_ch        (i_cmd_ch),
        .o_res_ch        (o_res_ch),
        .o_data_ctl      (w_data_ctl),
        .o_data_wdata    (w_data_wdata),
        .i_data_rdata    (w_data_rdata),
        .o_link_ctl      (w_link_ctl),
        .o_link_wdata    (w_link_wdata),
        .i_link_rdata    (w_link_rdata)
    );

    tcmq_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_data_ctl.we),
        .i_waddr (w_data_ctl.waddr),
        .i_wdata (w_data_wdata),
        .i_re    (w_data_ctl.re),
        .i_raddr (w_data_ctl.raddr),
        .o_rdata (w_data_rdata)
    );

    tcmq_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUE_DEPTH)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_ctl.we),
        .i_waddr (w_link_ctl.waddr),
        .i_wdata (w_link_wdata),
        .i_re    (w_link_ctl.re),
        .i_raddr (w_link_ctl.raddr),
        .o_rdata (w_link_rdata)
    );
endmodule

### tb/two_class_message_queue_with_revoke_tb.sv
// ----------------------------------------------------------------------------
// two_class_message_queue_with_revoke_tb
// Drives enqueue, dequeue and revoke commands with random handshake gaps,
// predicts the result beats with a linked-list model of the queue, and checks
// every result beat field by field in order.
// ----------------------------------------------------------------------------
module two_class_message_queue_with_revoke_tb;
    import tcmq_pkg::*;

    class queue_scoreboard;
        t_result pending[$];
        int      errors;
        bit      sig_en;
        logic [HANDLE_W-1:0] hnd[QUEUE_DEPTH];
        logic [TAG_W-1:0]    tg[QUEUE_DEPTH];
        int      lnk[QUEUE_DEPTH];
        bit      freemap[QUEUE_DEPTH];
        int      head, tail, ptail, occ;
        bit      pvalid;

        function new();
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                freemap[i] = 1;
                lnk[i] = 0;
            end
            head = 0; tail = 0; ptail = 0; occ = 0; pvalid = 0;
            errors = 0; sig_en = 0;
        endfunction

        function void push(t_kind k, t_status st, logic [15:0] h, logic [15:0] t,
                           int cnt, bit sg, bit lst);
            t_result r;
            r.kind = k; r.status = st; r.out_handle = h; r.out_tag = t;
            r.revoked_count = CNT_W'(cnt); r.signal = sg; r.last = lst;
            pending.push_back(r);
        endfunction

        function void note_command(t_cmd c, bit prio, logic [15:0] h, logic [15:0] t,
                                   bit all, int lim);
            int s, cur, prv, nxt, did, n;
            bit have_prev;
            bit sg;
            case (c)
                CMD_ENQ: begin
                    s = -1;
                    if (occ < QUEUE_DEPTH)
                        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) if (freemap[i]) s = i;
                    if (s < 0) begin
                        push(KIND_ACK, ST_FULL, 0, 0, 0, 0, 1);
                    end else begin
                        sg = 0;
                        freemap[s] = 0; hnd[s] = h; tg[s] = t;
                        if (occ == 0) begin
                            head = s; tail = s; ptail = s; pvalid = prio; sg = sig_en;
                        end else if (prio) begin
                            if (!pvalid) begin
                                lnk[s] = head; head = s;
                            end else begin
                                lnk[s] = lnk[ptail]; lnk[ptail] = s;
                                if (tail == ptail) tail = s;
                            end
                            ptail = s; pvalid = 1;
                        end else begin
                            lnk[tail] = s; tail = s;
                        end
                        occ++;
                        push(KIND_ACK, ST_OK, 0, 0, 0, sg, 1);
                    end
                end
                CMD_DEQ: begin
                    if (occ == 0) begin
                        push(KIND_DEQ, ST_EMPTY, 0, 0, 0, 0, 1);
                    end else begin
                        s = head;
                        push(KIND_DEQ, ST_OK, hnd[s], tg[s], 0, 0, 1);
                        if (pvalid && ptail == s) pvalid = 0;
                        head = lnk[s]; freemap[s] = 1; occ--;
                    end
                end
                CMD_REVOKE: begin
                    n = occ; did = 0; cur = head; prv = 0; have_prev = 0;
                    for (int i = 0; i < n; i++) begin
                        nxt = lnk[cur];
                        if (all || tg[cur] == t) begin
                            if (!have_prev) head = nxt; else lnk[prv] = nxt;
                            if (tail == cur) tail = have_prev ? prv : 0;
                            if (pvalid && ptail == cur) begin
                                if (have_prev) ptail = prv; else pvalid = 0;
                            end
                            freemap[cur] = 1; occ--; did++;
                            push(KIND_REVOKED, ST_OK, hnd[cur], tg[cur], did, 0, 0);
                            if (lim != 0 && did >= lim) break;
                        end else begin
                            prv = cur; have_prev = 1;
                        end
                        cur = nxt;
                    end
                    push(KIND_DONE, ST_OK, 0, 0, did, 0, 1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat %p", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    tcmq_in_if  cmd_ch();
    tcmq_out_if res_ch();
    tcmq_cfg_if cfg_ch();

    two_class_message_queue_with_revoke dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_ch (cmd_ch.sink),
        .o_res_ch (res_ch.source),
        .i_cfg_ch (cfg_ch.sink)
    );

    queue_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_off;
    longint cycles;
    logic [15:0] tag_pool[4];

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 400000) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Receiver: random stalls plus an optional long hold-off.
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            r.kind = res_ch.kind; r.status = res_ch.status;
            r.out_handle = res_ch.out_handle; r.out_tag = res_ch.out_tag;
            r.revoked_count = res_ch.revoked_count; r.signal = res_ch.signal;
            r.last = res_ch.last;
            board.check_result(r);
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            res_ch.ready <= 0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_cmd(t_cmd c, bit prio, logic [15:0] h, logic [15:0] t,
                            bit all, logic [5:0] lim);
        if ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        cmd_ch.valid <= 1;
        cmd_ch.cmd <= c; cmd_ch.high_priority <= prio;
        cmd_ch.payload_handle <= h; cmd_ch.context_tag <= t;
        cmd_ch.revoke_all <= all; cmd_ch.revoke_limit <= lim;
        do @(posedge i_clk); while (!cmd_ch.ready);
        board.note_command(c, prio, h, t, all, lim);
    endtask

    task automatic drain();
        cmd_ch.valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cfg(bit v);
        cfg_ch.valid <= 1;
        cfg_ch.data <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.sig_en = v;
        cfg_ch.valid <= 0;
    endtask

    task automatic random_cmd();
        int p;
        logic [15:0] t;
        p = $urandom_range(99);
        t = ($urandom_range(3) != 0) ? tag_pool[$urandom_range(3)] : 16'($urandom);
        if (p < 50)
            send_cmd(CMD_ENQ, 1'($urandom_range(1)), 16'($urandom), t, 1'b0,
                     6'($urandom));
        else if (p < 82)
            send_cmd(CMD_DEQ, 1'($urandom_range(1)), 16'($urandom), t,
                     1'($urandom_range(1)), 6'($urandom));
        else if (p < 97)
            send_cmd(CMD_REVOKE, 1'($urandom_range(1)), 16'($urandom), t,
                     ($urandom_range(4) == 0),
                     ($urandom_range(1) ? 6'd0 : 6'($urandom_range(63))));
        else
            send_cmd(CMD_NONE, 1'($urandom_range(1)), 16'($urandom), t,
                     1'($urandom_range(1)), 6'($urandom));
    endtask

    initial begin
        board = new();
        send_idle_pct = 0; recv_idle_pct = 0; hold_off = 0;
        tag_pool[0] = 16'h0000; tag_pool[1] = 16'hFFFF;
        tag_pool[2] = 16'h1234; tag_pool[3] = 16'hA5A5;
        i_rst_n = 0;
        cmd_ch.valid = 0; cmd_ch.cmd = CMD_NONE; cmd_ch.high_priority = 0;
        cmd_ch.payload_handle = 0; cmd_ch.context_tag = 0;
        cmd_ch.revoke_all = 0; cmd_ch.revoke_limit = 0;
        res_ch.ready = 0;
        cfg_ch.valid = 0; cfg_ch.data = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty cases, signal, priority order, revoke variants.
        send_cmd(CMD_DEQ, 0, 0, 0, 0, 0);
        send_cmd(CMD_REVOKE, 0, 0, 0, 1, 0);
        send_cmd(CMD_ENQ, 0, 16'hFFFF, 16'hFFFF, 0, 0);
        drain();
        write_cfg(1);
        send_cmd(CMD_DEQ, 0, 0, 0, 0, 0);
        send_cmd(CMD_ENQ, 1, 16'h0001, 16'h0000, 0, 0);
        send_cmd(CMD_ENQ, 0, 16'h0002, 16'h1234, 0, 0);
        send_cmd(CMD_ENQ, 1, 16'h0003, 16'h1234, 0, 0);
        send_cmd(CMD_ENQ, 1, 16'h0004, 16'h0000, 0, 0);
        send_cmd(CMD_NONE, 1, 16'hFFFF, 16'hFFFF, 1, 6'h3F);
        send_cmd(CMD_REVOKE, 0, 0, 16'h1234, 0, 1);
        send_cmd(CMD_REVOKE, 0, 0, 16'h0000, 0, 0);
        send_cmd(CMD_REVOKE, 0, 0, 16'h5555, 0, 6'h3F);
        send_cmd(CMD_DEQ, 0, 0, 0, 0, 0);
        send_cmd(CMD_DEQ, 0, 0, 0, 0, 0);
        // Fill past full, then revoke everything with a partial limit first.
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            send_cmd(CMD_ENQ, i[0], 16'(i), tag_pool[i % 4], 0, 0);
        send_cmd(CMD_REVOKE, 0, 0, 0, 1, 6'd5);
        send_cmd(CMD_REVOKE, 0, 0, 0, 1, 6'd0);
        drain();
        write_cfg(0);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 50 : 0;
            recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 38 : 0;
            if (ph == 1) hold_off = 300;
            for (int i = 0; i < 150; i++) random_cmd();
            drain();
            write_cfg(ph != 1);
        end
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

### files.f
hw/rtl/tcmq_pkg.sv
hw/rtl/tcmq_in_if.sv
hw/rtl/tcmq_out_if.sv
hw/rtl/tcmq_cfg_if.sv
hw/rtl/tcmq_ram.sv
hw/rtl/tcmq_seq.sv
hw/rtl/two_class_message_queue_with_revoke.sv
tb/two_class_message_queue_with_revoke_tb.sv
